// ===== rtl/sector_bloom_filter_unit_defines.svh =====
// Assertion macros shared by the sector Bloom filter RTL.
// No dependencies; included by the top level only.
`ifndef SECTOR_BLOOM_FILTER_UNIT_DEFINES_SVH
`define SECTOR_BLOOM_FILTER_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle, disabled during reset.
`define SBF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle, disabled during reset.
`define SBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle, checked through reset too.
`define SBF_ASSERT_NEXT_ANY(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sbf_pkg.sv =====
// Types and constants of the sector Bloom filter.
// No dependencies; imported by every module of the block.
package sbf_pkg;

    localparam int SEL_W       = 15;  // sector select before the store wrap
    localparam int HASH_W      = 64;
    localparam int IDX_W       = 14;
    localparam int WORD_W      = 64;
    localparam int SB_W        = 4;
    localparam int POS_W       = 6;   // bit position within a sector word
    localparam int BYTE_W      = 8;
    localparam int HASH_BYTE_FIRST = 4;
    localparam int HASH_BYTE_LAST  = 7;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [SB_W-1:0] SB_RESET = 4'd14;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_PROBE  = 2'd1,
        MODE_MERGE  = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [SEL_W-1:0]   sel;
        logic [WORD_W-1:0]  operand;
    } t_sbf_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_sbf_qstat;

    typedef struct packed {
        logic clearing;
        logic out_load;
    } t_sbf_status;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_QUOT,
        BS_READ,
        BS_EXEC
    } t_back_state;

endpackage

// ===== rtl/sbf_queue.sv =====
// Two-entry operation queue between the front and back of the filter.
// Depends on sbf_pkg.
module sbf_queue
    import sbf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_sbf_op    i_entry,
    input  logic       i_pop,
    output t_sbf_op    o_entry,
    output t_sbf_qstat o_stat
);

    t_sbf_op             r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    assign o_entry    = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// ===== rtl/sbf_front.sv =====
// Front end: takes input transfers, holds the sector_bits register and
// turns each item into a sector select and operand word. Depends on sbf_pkg.
module sbf_front
    import sbf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_mode,
    input  logic [HASH_W-1:0] i_hash_value,
    input  logic [IDX_W-1:0]  i_sector_index,
    input  logic [WORD_W-1:0] i_sector_word,
    input  logic              i_cfg_valid,
    input  logic [SB_W-1:0]   i_cfg_data,
    input  t_sbf_qstat        i_qstat,
    input  t_sbf_status       i_bstat,
    output logic              o_push,
    output t_sbf_op           o_entry
);

    logic [SB_W-1:0]   r_sector_bits;
    logic [WORD_W-1:0] hash_mask;
    logic [SEL_W-1:0]  sel_mask;
    logic [SEL_W-1:0]  raw_sel;
    t_mode             mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector_bits <= SB_RESET;
        end else if (i_cfg_valid) begin
            r_sector_bits <= i_cfg_data;
        end
    end

    // Bytes four to seven of the hash each set one bit of the probe mask.
    always_comb begin
        hash_mask = '0;
        for (int b = HASH_BYTE_FIRST; b <= HASH_BYTE_LAST; b++) begin
            hash_mask[i_hash_value[b*BYTE_W +: POS_W]] = 1'b1;
        end
    end

    // With sector_bits at fifteen the shift leaves zero and the mask is all ones.
    assign sel_mask = (SEL_W'(1) << r_sector_bits) - SEL_W'(1);
    assign mode     = t_mode'(i_mode);

    always_comb begin
        case (mode)
            MODE_INSERT, MODE_PROBE: begin
                raw_sel         = i_hash_value[SEL_W-1:0];
                o_entry.operand = hash_mask;
            end
            MODE_MERGE: begin
                raw_sel         = SEL_W'(i_sector_index);
                o_entry.operand = i_sector_word;
            end
            default: begin
                raw_sel         = SEL_W'(i_sector_index);
                o_entry.operand = '0;
            end
        endcase
        o_entry.mode = mode;
        o_entry.sel  = raw_sel & sel_mask;
    end

    assign o_stall = i_qstat.full | i_bstat.clearing;
    assign o_push  = i_valid & ~o_stall;

endmodule

// ===== rtl/sbf_back.sv =====
// Back end: sector store, clearing sweep, read-modify-write sequencer and
// the result register. Depends on sbf_pkg.
module sbf_back
    import sbf_pkg::*;
#(
    parameter int MAX_SECTORS = 16384
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_sbf_op           i_entry,
    input  t_sbf_qstat        i_qstat,
    output logic              o_pop,
    output t_sbf_status       o_stat,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_done_mode,
    output logic              o_hit,
    output logic [WORD_W-1:0] o_word_out
);

    localparam int AW = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_SECTORS - 1);
    // A select narrower than the store needs no wrap and no quotient step.
    localparam bit USE_RECIP = (MAX_SECTORS < (1 << SEL_W));

    t_back_state       r_state;
    t_back_state       n_state;
    t_sbf_op           r_op;
    logic [AW-1:0]     r_clr_addr;
    logic [AW-1:0]     r_index;
    logic [AW-1:0]     index_calc;
    logic [WORD_W-1:0] r_store [MAX_SECTORS];
    logic [WORD_W-1:0] r_rdata;
    logic              r_out_valid;
    t_mode             r_out_mode;
    logic              r_out_hit;
    logic [WORD_W-1:0] r_out_word;

    logic              out_free;
    logic              quot_en;
    logic              rd_en;
    logic              exec_fire;
    logic              clearing;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] merged;
    logic              probe_hit;

    generate
        if (USE_RECIP) begin : g_recip
            // Exact floor division of a SEL_W-bit select by the store depth.
            localparam int MW = $clog2(MAX_SECTORS);
            localparam int K  = SEL_W + MW;
            localparam int RW = SEL_W + 1;
            localparam longint unsigned RECIP =
                ((64'd1 << K) + 64'(MAX_SECTORS) - 64'd1) / 64'(MAX_SECTORS);

            logic [SEL_W-1:0]      r_quot;
            logic [SEL_W+RW-1:0]   prod;
            logic [2*SEL_W-1:0]    qm;

            assign prod = (SEL_W+RW)'(r_op.sel) * (SEL_W+RW)'(RW'(RECIP));

            always_ff @(posedge i_clk) begin
                if (quot_en) begin
                    r_quot <= SEL_W'(prod >> K);
                end
            end

            assign qm         = (2*SEL_W)'(r_quot) * (2*SEL_W)'(SEL_W'(MAX_SECTORS));
            assign index_calc = AW'(r_op.sel - qm[SEL_W-1:0]);
        end else begin : g_direct
            assign index_calc = AW'(r_op.sel);
        end
    endgenerate

    assign out_free = ~r_out_valid | ~i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_CLEAR: begin
                if (r_clr_addr == CLR_LAST) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (!i_qstat.empty) begin
                    n_state = USE_RECIP ? BS_QUOT : BS_READ;
                end
            end
            BS_QUOT: n_state = BS_READ;
            BS_READ: n_state = BS_EXEC;
            BS_EXEC: begin
                if (out_free) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_CLEAR;
        endcase
    end

    always_comb begin
        clearing  = 1'b0;
        o_pop     = 1'b0;
        quot_en   = 1'b0;
        rd_en     = 1'b0;
        exec_fire = 1'b0;
        case (r_state)
            BS_CLEAR: clearing  = 1'b1;
            BS_IDLE:  o_pop     = ~i_qstat.empty;
            BS_QUOT:  quot_en   = 1'b1;
            BS_READ:  rd_en     = 1'b1;
            BS_EXEC:  exec_fire = out_free;
            default:  clearing  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BS_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_entry;
        end
        if (rd_en) begin
            r_index <= index_calc;
        end
    end

    assign merged    = r_rdata | r_op.operand;
    assign probe_hit = ((r_rdata & r_op.operand) == r_op.operand);

    always_comb begin
        case (r_op.mode)
            MODE_INSERT, MODE_MERGE: mem_we = exec_fire;
            default:                 mem_we = 1'b0;
        endcase
        mem_we    = mem_we | clearing;
        mem_waddr = clearing ? r_clr_addr : r_index;
        mem_wdata = clearing ? '0 : merged;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rdata <= r_store[index_calc];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_out_mode <= r_op.mode;
            r_out_hit  <= (r_op.mode == MODE_PROBE) ? probe_hit : 1'b0;
            r_out_word <= (r_op.mode == MODE_READ) ? r_rdata : '0;
        end
    end

    assign o_stat.clearing = clearing;
    assign o_stat.out_load = exec_fire;
    assign o_valid         = r_out_valid;
    assign o_done_mode     = r_out_mode;
    assign o_hit           = r_out_hit;
    assign o_word_out      = r_out_word;

endmodule

// ===== rtl/sector_bloom_filter_unit.sv =====
// Top level of the sector Bloom filter; depends on sbf_pkg, sbf_front,
// sbf_queue, sbf_back and sector_bloom_filter_unit_defines.svh.
//
// Usage: the input channel (i_valid / o_stall) carries one operation per
// transfer: insert or probe a 64-bit hash, merge a word into a sector, or
// read a sector. The output channel (o_valid / i_stall) returns exactly one
// result per operation, in order. The configuration channel (i_cfg_valid /
// o_cfg_ready) writes sector_bits and is always ready; write it only while
// the block is idle.
// Each operation passes through the back-end steps dequeue, quotient, store
// read and update, the quotient step only when the store depth is below 32768
// sectors; that sequencer around the single store port sets throughput.
// A result is loaded into the result register by its update step. A two-entry
// queue lets the front keep accepting while the back works or the result
// register is stalled; when the queue is full o_stall rises. After reset the
// store is swept to zero, one sector per cycle through all MAX_SECTORS
// sectors, with o_stall high; sector_bits resets to 14.
`include "sector_bloom_filter_unit_defines.svh"

module sector_bloom_filter_unit
    import sbf_pkg::*;
#(
    parameter int MAX_SECTORS = 16384
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_mode,
    input  logic [HASH_W-1:0] i_hash_value,
    input  logic [IDX_W-1:0]  i_sector_index,
    input  logic [WORD_W-1:0] i_sector_word,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_done_mode,
    output logic              o_hit,
    output logic [WORD_W-1:0] o_word_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SB_W-1:0]   i_cfg_data
);

    logic        push;
    logic        pop;
    t_sbf_op     push_entry;
    t_sbf_op     head_entry;
    t_sbf_qstat  qstat;
    t_sbf_status bstat;

    assign o_cfg_ready = 1'b1;

    sbf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_hash_value   (i_hash_value),
        .i_sector_index (i_sector_index),
        .i_sector_word  (i_sector_word),
        .i_cfg_valid    (i_cfg_valid & o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_qstat        (qstat),
        .i_bstat        (bstat),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    sbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_stat  (qstat)
    );

    sbf_back #(
        .MAX_SECTORS (MAX_SECTORS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (head_entry),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_stat      (bstat),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_done_mode (o_done_mode),
        .o_hit       (o_hit),
        .o_word_out  (o_word_out)
    );

    `SBF_ASSERT_NEXT_ANY(a_clear_after_reset, i_clk, !i_rst_n, bstat.clearing,
        "store sweep did not start after reset")
    `SBF_ASSERT_SAME(a_no_accept_while_clearing, i_clk, i_rst_n, bstat.clearing, o_stall,
        "input not stalled during store sweep")
    `SBF_ASSERT_SAME(a_pop_needs_entry, i_clk, i_rst_n, pop, !qstat.empty,
        "back end dequeued from an empty queue")
    `SBF_ASSERT_NEXT(a_result_presented, i_clk, i_rst_n, bstat.out_load, o_valid,
        "loaded result not presented")

endmodule

// ===== sim/sbf_checker.sv =====
// Scoreboard for the sector Bloom filter: watches the operation, result and
// register channels, keeps its own copy of the sector store and compares.
// Depends on sbf_pkg.
module sbf_checker
    import sbf_pkg::*;
#(
    parameter int MAX_SECTORS = 16384
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [1:0]        i_mode,
    input  logic [HASH_W-1:0] i_hash_value,
    input  logic [IDX_W-1:0]  i_sector_index,
    input  logic [WORD_W-1:0] i_sector_word,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [1:0]        i_done_mode,
    input  logic              i_hit,
    input  logic [WORD_W-1:0] i_word_out,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [SB_W-1:0]   i_cfg_data,
    output int                o_pending,
    output int                o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_mode             mode;
        logic              hit;
        logic [WORD_W-1:0] word;
    } t_bloom_result;

    logic [WORD_W-1:0] sector_mem [MAX_SECTORS];
    logic [SB_W-1:0]   sector_bits = SB_RESET;
    t_bloom_result     expected_q [$];
    int                fail_total = 0;

    assign o_fail_count = fail_total;

    // One bit per hash byte 4..7; only the low six bits of each byte count.
    function automatic logic [WORD_W-1:0] hash_bit_mask(input logic [HASH_W-1:0] h);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int b = HASH_BYTE_FIRST; b <= HASH_BYTE_LAST; b++)
            m[h[b*BYTE_W +: POS_W]] = 1'b1;
        return m;
    endfunction

    // A sector_bits of 15 keeps 15 bits, which the store depth then wraps.
    function automatic int sector_of(input logic [HASH_W-1:0] raw);
        logic [HASH_W-1:0] sel;
        sel = raw & ((64'd1 << sector_bits) - 64'd1);
        return int'(sel % MAX_SECTORS);
    endfunction

    function automatic t_bloom_result apply_op(input t_mode mode,
                                               input logic [HASH_W-1:0] h,
                                               input logic [HASH_W-1:0] idx,
                                               input logic [WORD_W-1:0] w);
        t_bloom_result r;
        int s;
        logic [WORD_W-1:0] m;
        r.mode = mode;
        r.hit = 1'b0;
        r.word = '0;
        case (mode)
            MODE_INSERT: begin
                s = sector_of(h);
                sector_mem[s] |= hash_bit_mask(h);
            end
            MODE_PROBE: begin
                s = sector_of(h);
                m = hash_bit_mask(h);
                r.hit = ((sector_mem[s] & m) == m);
            end
            MODE_MERGE: begin
                s = sector_of(idx);
                sector_mem[s] |= w;
            end
            default: begin
                s = sector_of(idx);
                r.word = sector_mem[s];
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_bloom_result want;
        t_bloom_result next_res;
        if (!i_rst_n) begin
            sector_bits = SB_RESET;
            foreach (sector_mem[k]) sector_mem[k] = '0;
            expected_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                sector_bits = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result transfer with nothing outstanding, done_mode %0d",
                             $time, i_done_mode);
                    fail_total++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_done_mode !== want.mode) begin
                        $display("%0t: done_mode expected %0d actual %0d",
                                 $time, want.mode, i_done_mode);
                        fail_total++;
                    end
                    if (i_hit !== want.hit) begin
                        $display("%0t: hit expected %0b actual %0b", $time, want.hit, i_hit);
                        fail_total++;
                    end
                    if (i_word_out !== want.word) begin
                        $display("%0t: word_out expected %h actual %h",
                                 $time, want.word, i_word_out);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                next_res = apply_op(t_mode'(i_mode), i_hash_value,
                                    HASH_W'(i_sector_index), i_sector_word);
                expected_q = {expected_q, next_res};
            end
            o_pending <= expected_q.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for sector_bloom_filter_unit: clock, reset, operation and
// register stimulus, result back-pressure and the final verdict.
// Depends on sbf_pkg, the block's RTL and sim/sbf_checker.sv.
module tb;
    import sbf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [1:0]        i_mode;
    logic [HASH_W-1:0] i_hash_value;
    logic [IDX_W-1:0]  i_sector_index;
    logic [WORD_W-1:0] i_sector_word;
    logic              o_valid;
    logic              i_stall;
    logic [1:0]        o_done_mode;
    logic              o_hit;
    logic [WORD_W-1:0] o_word_out;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [SB_W-1:0]   i_cfg_data;

    int pending;
    int fail_count;
    int send_burst = 0;
    logic [HASH_W-1:0] inserted_hashes [$];

    sector_bloom_filter_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_hash_value   (i_hash_value),
        .i_sector_index (i_sector_index),
        .i_sector_word  (i_sector_word),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_done_mode    (o_done_mode),
        .o_hit          (o_hit),
        .o_word_out     (o_word_out),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    sbf_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_mode         (i_mode),
        .i_hash_value   (i_hash_value),
        .i_sector_index (i_sector_index),
        .i_sector_word  (i_sector_word),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_done_mode    (o_done_mode),
        .i_hit          (o_hit),
        .i_word_out     (o_word_out),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // One operation transfer, after a random gap unless a burst is running.
    task automatic issue_op(input t_mode mode, input logic [HASH_W-1:0] h,
                            input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] w);
        int gap;
        if (send_burst > 0) begin
            send_burst--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 15) == 0)
                send_burst = $urandom_range(8, 40);
            gap = $urandom_range(0, 10);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_mode         <= mode;
        i_hash_value   <= h;
        i_sector_index <= idx;
        i_sector_word  <= w;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_sector_bits(input logic [SB_W-1:0] value);
        i_valid <= 1'b0;
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Runs with the reset value of 14 sector bits.
    task automatic directed_ops();
        issue_op(MODE_READ,   '0, 14'd0, '0);
        issue_op(MODE_PROBE,  64'd0, '0, '0);
        issue_op(MODE_INSERT, 64'd0, '0, '0);
        issue_op(MODE_PROBE,  64'd0, '0, '0);
        issue_op(MODE_INSERT, '1, '0, '0);
        issue_op(MODE_PROBE,  '1, '0, '0);
        issue_op(MODE_READ,   '0, 14'h3FFF, '0);
        issue_op(MODE_MERGE,  '0, 14'h3FFF, '1);
        issue_op(MODE_READ,   '0, 14'h3FFF, '1);
        issue_op(MODE_MERGE,  '0, 14'd1, 64'hA5A5_A5A5_A5A5_A5A5);
        issue_op(MODE_READ,   '0, 14'd1, '0);
        issue_op(MODE_MERGE,  '0, 14'd1, 64'h5A5A_5A5A_5A5A_5A5A);
        issue_op(MODE_READ,   '0, 14'd1, '0);
        // All four bytes pick the same bit, so the mask has a single bit.
        issue_op(MODE_INSERT, 64'h2A2A_2A2A_0000_0005, '0, '0);
        issue_op(MODE_PROBE,  64'h2A2B_2A2A_0000_0005, '0, '0);
        // The two high bits of each byte are dropped.
        issue_op(MODE_PROBE,  64'hEAAA_6AEA_0000_0005, '0, '0);
        issue_op(MODE_READ,   '0, 14'd5, '0);
        // Hash bits above the sector select do not move the sector.
        issue_op(MODE_INSERT, 64'h0102_0304_FFFF_C000, '0, '0);
        issue_op(MODE_READ,   '0, 14'd0, '0);
        issue_op(MODE_PROBE,  64'h0102_0304_0000_4000, '0, '0);
        issue_op(MODE_READ,   '0, 14'h2000, '0);
        issue_op(MODE_MERGE,  '0, 14'd0, 64'd0);
        issue_op(MODE_READ,   '0, 14'd0, '0);
    endtask

    // Mostly hashes reused from earlier inserts, so probes hit and reads see data.
    task automatic random_op();
        int r;
        int sub;
        logic have;
        logic [HASH_W-1:0] h;
        logic [HASH_W-1:0] pooled;
        logic [WORD_W-1:0] w;
        logic [IDX_W-1:0]  idx;
        h = rand64();
        w = rand64();
        idx = IDX_W'($urandom_range(0, 16383));
        have = inserted_hashes.size() > 0;
        pooled = have ? inserted_hashes[$urandom_range(0, inserted_hashes.size() - 1)] : h;
        r = $urandom_range(0, 99);
        sub = $urandom_range(0, 9);
        if (r < 30) begin
            if (have && sub < 3)
                h = {32'($urandom), pooled[31:0]};
            inserted_hashes = {inserted_hashes, h};
            if (inserted_hashes.size() > 64)
                void'(inserted_hashes.pop_front());
            issue_op(MODE_INSERT, h, idx, w);
        end else if (r < 65) begin
            if (have && sub < 6) begin
                h = pooled;
            end else if (have && sub < 8) begin
                h = pooled;
                h[($urandom_range(HASH_BYTE_FIRST, HASH_BYTE_LAST))*BYTE_W +: BYTE_W] =
                    BYTE_W'($urandom);
            end
            issue_op(MODE_PROBE, h, idx, w);
        end else if (r < 80) begin
            if (sub < 5)
                idx = pooled[IDX_W-1:0];
            if (sub % 2 == 0)
                w = w & rand64() & rand64();
            issue_op(MODE_MERGE, h, idx, w);
        end else begin
            if (sub < 7)
                idx = pooled[IDX_W-1:0];
            issue_op(MODE_READ, h, idx, w);
        end
    endtask

    // Result side: random stalls, stall-free bursts and two long hold-offs.
    initial begin
        int gap;
        int burst;
        int taken;
        burst = 0;
        taken = 0;
        i_stall <= 1'b0;
        wait (i_rst_n);
        forever begin
            if (taken == 200 || taken == 650) begin
                gap = 150;
            end else if (burst > 0) begin
                burst--;
                gap = 0;
            end else begin
                if ($urandom_range(0, 15) == 0)
                    burst = $urandom_range(8, 40);
                gap = $urandom_range(0, 10);
            end
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            taken++;
        end
    end

    initial begin
        logic [SB_W-1:0] phase_bits [5];
        phase_bits[0] = 4'd0;
        phase_bits[1] = 4'd15;
        phase_bits[2] = 4'd4;
        phase_bits[3] = SB_W'($urandom_range(1, 13));
        phase_bits[4] = 4'd14;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_mode         <= MODE_INSERT;
        i_hash_value   <= '0;
        i_sector_index <= '0;
        i_sector_word  <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_data     <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed_ops();
        repeat (150) random_op();
        foreach (phase_bits[p]) begin
            write_sector_bits(phase_bits[p]);
            repeat (155) random_op();
        end
        i_valid <= 1'b0;
        drain();
        if (fail_count == 0 && pending == 0)
            $display("sector_bloom_filter_unit regression: pass");
        else
            $display("sector_bloom_filter_unit regression: fail");
        $finish;
    end

    // Covers the store sweep after reset plus the slowest legal run many times over.
    initial begin
        #4_000_000;
        $display("sector_bloom_filter_unit regression: fail");
        $finish;
    end

endmodule
